### design/vtpd_pkg.sv
// Package with shared widths, constants and types for the vertex transform unit.
package vtpd_pkg;

	localparam int CoordWidth = 32;
	localparam int CoefWidth  = 16;
	localparam int CrdFrac    = CoordWidth / 2;
	localparam int CfFrac     = CoefWidth / 2;
	// Transformed sums fit comfortably in this width.
	localparam int SumWidth   = 2 * CoordWidth + 4;
	// Numerator t * 2^CrdFrac, magnitude only.
	localparam int NumWidth   = SumWidth + CrdFrac;
	// Quotient bits produced: enough to exceed the coordinate range.
	localparam int QuoWidth   = CoordWidth + 1;
	// One divide cell retires one quotient bit.
	localparam int NumCells   = NumWidth;

	localparam logic [1:0] RegRow0 = 2'd0;
	localparam logic [1:0] RegRow1 = 2'd1;
	localparam logic [1:0] RegRow2 = 2'd2;
	localparam logic [1:0] RegRow3 = 2'd3;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [CoefWidth-1:0]  coef_t;
	typedef logic signed [SumWidth-1:0]   sum_t;
	typedef logic [NumWidth-1:0]          mag_t;

	// Per-lane divide state handed from cell to cell.
	typedef struct packed {
		mag_t rem;
		mag_t num;
		logic [QuoWidth-1:0] quo;
		logic big;
		logic neg;
	} lane_t;

	// Per-item context that travels with the divide lanes.
	typedef struct packed {
		logic valid;
		logic wz;
		mag_t div;
		coord_t pass_x;
		coord_t pass_y;
		coord_t pass_z;
		logic pass_sat;
	} ctx_t;

	// Product truncated toward zero to coordinate fraction bits.
	function automatic sum_t scale_prod(coord_t a, coef_t m);
		logic signed [CoordWidth+CoefWidth-1:0] p;
		logic [CoordWidth+CoefWidth-1:0] mag;
		sum_t r;
		p = a * m;
		mag = p[CoordWidth+CoefWidth-1] ? -p : p;
		r = sum_t'(mag >> CfFrac);
		return p[CoordWidth+CoefWidth-1] ? -r : r;
	endfunction

	// Clamp a sum to the coordinate range.
	function automatic coord_t clamp_sum(sum_t v);
		sum_t hi;
		sum_t lo;
		hi = sum_t'({1'b0, {(CoordWidth-1){1'b1}}});
		lo = -hi - sum_t'(1);
		if (v > hi) return coord_t'(hi);
		if (v < lo) return coord_t'(lo);
		return v[CoordWidth-1:0];
	endfunction

	function automatic logic sum_out_of_range(sum_t v);
		sum_t hi;
		sum_t lo;
		hi = sum_t'({1'b0, {(CoordWidth-1){1'b1}}});
		lo = -hi - sum_t'(1);
		return (v > hi) || (v < lo);
	endfunction

endpackage

### design/vtpd_xform.sv
// Matrix transform stages: products, then column sums and divide setup.
module vtpd_xform import vtpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  coord_t x,
	input  coord_t y,
	input  coord_t z,
	input  logic [63:0] row0,
	input  logic [63:0] row1,
	input  logic [63:0] row2,
	input  logic [63:0] row3,
	output ctx_t ctx,
	output lane_t lane_x,
	output lane_t lane_y,
	output lane_t lane_z
);

	sum_t prod_s1 [3][4];
	sum_t bias_s1 [4];
	logic valid_s1;
	sum_t t_c [4];

	// Stage one: twelve products plus the scaled row 3 entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[0][c] <= scale_prod(x, coef_t'(row0[16*c +: CoefWidth]));
				prod_s1[1][c] <= scale_prod(y, coef_t'(row1[16*c +: CoefWidth]));
				prod_s1[2][c] <= scale_prod(z, coef_t'(row2[16*c +: CoefWidth]));
				bias_s1[c] <= sum_t'(coef_t'(row3[16*c +: CoefWidth])) <<< (CrdFrac - CfFrac);
			end
		end
	end

	// Column sums.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			t_c[c] = prod_s1[0][c] + prod_s1[1][c] + prod_s1[2][c] + bias_s1[c];
		end
	end

	function automatic lane_t lane_init(sum_t t, sum_t w);
		lane_t l;
		sum_t m;
		m = t[SumWidth-1] ? -t : t;
		l.rem = '0;
		l.num = mag_t'(m) << CrdFrac;
		l.quo = '0;
		l.big = 1'b0;
		l.neg = t[SumWidth-1] ^ w[SumWidth-1];
		return l;
	endfunction

	// Stage two: set up the three divide lanes and the pass-through values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx <= '0;
		end else if (en) begin
			ctx.valid <= valid_s1;
			ctx.wz <= (t_c[3] == '0);
			ctx.div <= mag_t'(t_c[3][SumWidth-1] ? -t_c[3] : t_c[3]);
			ctx.pass_x <= clamp_sum(t_c[0]);
			ctx.pass_y <= clamp_sum(t_c[1]);
			ctx.pass_z <= clamp_sum(t_c[2]);
			ctx.pass_sat <= sum_out_of_range(t_c[0]) | sum_out_of_range(t_c[1])
				| sum_out_of_range(t_c[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_x <= lane_init(t_c[0], t_c[3]);
			lane_y <= lane_init(t_c[1], t_c[3]);
			lane_z <= lane_init(t_c[2], t_c[3]);
		end
	end

endmodule

### design/vtpd_div_cell.sv
// One restoring-divide cell: retires one numerator bit for three lanes.
module vtpd_div_cell import vtpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  ctx_t ctx_in,
	input  lane_t x_in,
	input  lane_t y_in,
	input  lane_t z_in,
	output ctx_t ctx_out,
	output lane_t x_out,
	output lane_t y_out,
	output lane_t z_out
);

	// Shift one bit into the remainder, subtract when it fits, track overflow.
	function automatic lane_t step(lane_t l, mag_t d);
		lane_t o;
		logic [NumWidth:0] r;
		logic [QuoWidth:0] q;
		logic [QuoWidth:0] lim;
		r = {l.rem, l.num[NumWidth-1]};
		q = {l.quo, 1'b0};
		if (r >= {1'b0, d}) begin
			r = r - {1'b0, d};
			q[0] = 1'b1;
		end
		lim = l.neg ? (QuoWidth+1)'(1) << (CoordWidth-1)
			: ((QuoWidth+1)'(1) << (CoordWidth-1)) - 1'b1;
		o.rem = r[NumWidth-1:0];
		o.num = l.num << 1;
		// Once the quotient passes the limit it stays saturated.
		o.big = l.big | (q > lim);
		o.quo = o.big ? l.quo : q[QuoWidth-1:0];
		o.neg = l.neg;
		return o;
	endfunction

	// Context travels alongside the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_out <= '0;
		end else if (en) begin
			ctx_out <= ctx_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= step(x_in, ctx_in.div);
			y_out <= step(y_in, ctx_in.div);
			z_out <= step(z_in, ctx_in.div);
		end
	end

endmodule

### design/vertex_transform_perspective_divide_unit.sv
// Top level of the vertex transform with perspective divide.
//  channel | handshake             | payload
//  cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//  in      | in_valid/in_ready     | in_x, in_y, in_z
//  out     | out_valid/out_ready   | out_x, out_y, out_z, w_was_zero, saturated
// One word is accepted per cycle while the pipeline advances.
// Latency is set by the row of divide cells, one quotient bit per cell.
// The whole pipeline advances when the output register is empty or being taken.
// Reset restores the identity matrix and empties the pipeline.
module vertex_transform_perspective_divide_unit import vtpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [63:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  coord_t in_x,
	input  coord_t in_y,
	input  coord_t in_z,
	output logic out_valid,
	input  logic out_ready,
	output coord_t out_x,
	output coord_t out_y,
	output coord_t out_z,
	output logic w_was_zero,
	output logic saturated
);

	logic [63:0] row_q [4];
	logic en;
	ctx_t ctx [NumCells+1];
	lane_t lx [NumCells+1];
	lane_t ly [NumCells+1];
	lane_t lz [NumCells+1];

	assign cfg_ready = 1'b1;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// Matrix registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= 64'h0000_0000_0000_0100;
			row_q[1] <= 64'h0000_0000_0100_0000;
			row_q[2] <= 64'h0000_0100_0000_0000;
			row_q[3] <= 64'h0100_0000_0000_0000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegRow0: row_q[0] <= cfg_data;
				RegRow1: row_q[1] <= cfg_data;
				RegRow2: row_q[2] <= cfg_data;
				RegRow3: row_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	vtpd_xform u_xform (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.x(in_x), .y(in_y), .z(in_z),
		.row0(row_q[0]), .row1(row_q[1]), .row2(row_q[2]), .row3(row_q[3]),
		.ctx(ctx[0]), .lane_x(lx[0]), .lane_y(ly[0]), .lane_z(lz[0])
	);

	// Row of divide cells.
	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		vtpd_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.ctx_in(ctx[i]), .x_in(lx[i]), .y_in(ly[i]), .z_in(lz[i]),
			.ctx_out(ctx[i+1]), .x_out(lx[i+1]), .y_out(ly[i+1]), .z_out(lz[i+1])
		);
	end

	function automatic coord_t finish(lane_t l);
		coord_t q;
		if (l.big) return l.neg ? {1'b1, {(CoordWidth-1){1'b0}}}
			: {1'b0, {(CoordWidth-1){1'b1}}};
		q = l.quo[CoordWidth-1:0];
		return l.neg ? -q : q;
	endfunction

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctx[NumCells].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_was_zero <= ctx[NumCells].wz;
			if (ctx[NumCells].wz) begin
				out_x <= ctx[NumCells].pass_x;
				out_y <= ctx[NumCells].pass_y;
				out_z <= ctx[NumCells].pass_z;
				saturated <= ctx[NumCells].pass_sat;
			end else begin
				out_x <= finish(lx[NumCells]);
				out_y <= finish(ly[NumCells]);
				out_z <= finish(lz[NumCells]);
				saturated <= lx[NumCells].big | ly[NumCells].big | lz[NumCells].big;
			end
		end
	end

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the vertex transform with perspective divide.
module tb;
	import vtpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DrainCycles = 200;
	localparam int CycleLimit  = 400000;
	localparam int RandPhases  = 12;
	localparam int RandWords   = 125;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   wz;
		logic   sat;
	} point_res_t;

	typedef struct {
		int     mset;
		coord_t x;
		coord_t y;
		coord_t z;
		bit     known;
		point_res_t res;
	} dir_row_t;

	// Matrix sets: identity, all zero, w from z, w zero with huge gain,
	// all -1/256, all max, all min, and a tiny w bias.
	localparam int NumSets = 8;
	localparam logic [63:0] MatSets [NumSets][4] = '{
		'{64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
		  64'h0000_0100_0000_0000, 64'h0100_0000_0000_0000},
		'{64'h0, 64'h0, 64'h0, 64'h0},
		'{64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
		  64'h0100_0100_0000_0000, 64'h0000_0000_0000_0000},
		'{64'h0000_0000_0000_7fff, 64'h0000_0000_8000_0000,
		  64'h0000_7fff_0000_0000, 64'h0000_0100_0100_0100},
		'{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
		  64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff},
		'{64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff,
		  64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff},
		'{64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
		  64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000},
		'{64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
		  64'h0000_0100_0000_0000, 64'h0001_0000_0000_0000}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = RegRow0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t in_x = '0;
	coord_t in_y = '0;
	coord_t in_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic w_was_zero;
	logic saturated;

	logic [63:0] matrix_rows [4];
	point_res_t pending_points [$];
	int mismatches = 0;
	int words_out = 0;
	int wz_seen = 0;
	int sat_seen = 0;
	int cycles = 0;
	int burst_left = 0;
	int recv_mode = 0;

	vertex_transform_perspective_divide_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_x(in_x), .in_y(in_y), .in_z(in_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.w_was_zero(w_was_zero), .saturated(saturated)
	);

	always #5 clk = ~clk;

	// Clamp a wide value to the coordinate range.
	function automatic coord_t clamp_coord(logic signed [127:0] v, inout logic sat);
		logic signed [127:0] hi;
		logic signed [127:0] lo;
		hi = (128'sd1 <<< (CoordWidth - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			sat = 1'b1;
			return coord_t'(hi);
		end
		if (v < lo) begin
			sat = 1'b1;
			return coord_t'(lo);
		end
		return coord_t'(v);
	endfunction

	// Row vector times matrix, then divide x, y, z by w unless w is zero.
	function automatic point_res_t project_point(coord_t px, coord_t py, coord_t pz);
		logic signed [127:0] pt [3];
		logic signed [127:0] acc [4];
		logic signed [127:0] cf;
		logic signed [127:0] prod;
		coord_t r [3];
		point_res_t res;
		logic sat;
		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		sat = 1'b0;
		for (int c = 0; c < 4; c++) begin
			cf = coef_t'(matrix_rows[3][16*c +: 16]);
			acc[c] = cf * (128'sd1 <<< (CrdFrac - CfFrac));
			for (int k = 0; k < 3; k++) begin
				cf = coef_t'(matrix_rows[k][16*c +: 16]);
				prod = pt[k] * cf;
				acc[c] += prod / (128'sd1 <<< CfFrac);
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (acc[3] == 0)
				r[k] = clamp_coord(acc[k], sat);
			else
				r[k] = clamp_coord((acc[k] <<< CrdFrac) / acc[3], sat);
		end
		res.x = r[0];
		res.y = r[1];
		res.z = r[2];
		res.wz = (acc[3] == 0);
		res.sat = sat;
		return res;
	endfunction

	// Receiver stall patterns, switched at random.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 300 == 0)
			recv_mode <= $urandom_range(0, 3);
		case (recv_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (cycles % 5 != 0);
		endcase
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result checker: a word moves at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %h %h %h", out_x, out_y, out_z);
			end else begin
				point_res_t want;
				want = pending_points.pop_front();
				if (want.x !== out_x || want.y !== out_y || want.z !== out_z ||
					want.wz !== w_was_zero || want.sat !== saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: exp %h %h %h wz=%b sat=%b got %h %h %h wz=%b sat=%b",
							words_out, want.x, want.y, want.z, want.wz, want.sat,
							out_x, out_y, out_z, w_was_zero, saturated);
				end
				wz_seen += w_was_zero;
				sat_seen += saturated;
			end
			words_out++;
		end
	end

	// Wait until all results are back and the pipeline has drained.
	task automatic wait_idle();
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Present one register write and hold it until it is taken.
	task automatic write_row(logic [1:0] idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		matrix_rows[idx] = value;
	endtask

	task automatic load_matrix(logic [63:0] m [4]);
		wait_idle();
		write_row(RegRow0, m[0]);
		write_row(RegRow1, m[1]);
		write_row(RegRow2, m[2]);
		write_row(RegRow3, m[3]);
		cfg_valid <= 1'b0;
	endtask

	// Send one point, with bursts and gaps; call at a rising edge.
	task automatic send_point(coord_t px, coord_t py, coord_t pz, bit known, point_res_t res);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_x <= px;
		in_y <= py;
		in_z <= pz;
		do @(negedge clk); while (!in_ready);
		pending_points.push_back(known ? res : project_point(px, py, pz));
		@(posedge clk);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return coord_t'($signed($urandom_range(0, 32'h1ffff)) - 32'sh10000);
			2: return coord_t'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
			3: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 32'sh0;
					3: return 32'sh00010000;
					default: return 32'shffff0000;
				endcase
			end
			default: return coord_t'($signed($urandom_range(0, 32'h1ff)) - 32'sh100);
		endcase
	endfunction

	function automatic logic [63:0] rand_row();
		logic [63:0] v;
		v = {$urandom, $urandom};
		// Mostly modest coefficients so that divides stay in range.
		if ($urandom_range(0, 2) != 0)
			for (int c = 0; c < 4; c++)
				v[16*c +: 16] = 16'($signed($urandom_range(0, 1023)) - 512);
		return v;
	endfunction

	dir_row_t dir_rows [$];
	logic [63:0] next_mat [4];
	int cur_set;
	point_res_t none;

	initial begin
		none = '0;
		// Identity passes points through unchanged.
		dir_rows = '{
			'{0, 32'sh0, 32'sh0, 32'sh0, 1, '{32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0}},
			'{0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1,
				'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0}},
			'{0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1,
				'{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, 1'b0}},
			'{0, 32'sh00010000, 32'shffff0000, 32'sh00000001, 1,
				'{32'sh00010000, 32'shffff0000, 32'sh00000001, 1'b0, 1'b0}},
			'{0, 32'sh55555555, 32'shaaaaaaaa, 32'shffffffff, 1,
				'{32'sh55555555, 32'shaaaaaaaa, 32'shffffffff, 1'b0, 1'b0}},
			// An all-zero matrix gives w zero and zero sums.
			'{1, 32'sh7fffffff, 32'sh80000000, 32'sh12345678, 1,
				'{32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b0}},
			'{1, 32'sh0, 32'sh0, 32'sh0, 1, '{32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b0}},
			// Perspective: w follows z, including z of zero.
			'{2, 32'sh00020000, 32'sh00030000, 32'sh00020000, 0, none},
			'{2, 32'sh00020000, 32'shfffd0000, 32'sh0, 0, none},
			'{2, 32'sh7fffffff, 32'sh80000000, 32'sh00000001, 0, none},
			'{2, 32'sh00010000, 32'sh00010000, 32'shffff0000, 0, none},
			// Large gains with w zero overflow without a divide.
			'{3, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, none},
			'{3, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, none},
			'{3, 32'sh00000100, 32'sh0, 32'sh0, 0, none},
			'{4, 32'sh7fffffff, 32'sh80000000, 32'sh0, 0, none},
			'{5, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, none},
			'{6, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, none},
			'{7, 32'sh00100000, 32'shfff00000, 32'sh00000001, 0, none}
		};
		for (int r = 0; r < 4; r++)
			matrix_rows[r] = MatSets[0][r];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		cur_set = 0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mset != cur_set) begin
				in_valid <= 1'b0;
				cur_set = dir_rows[i].mset;
				for (int r = 0; r < 4; r++)
					next_mat[r] = MatSets[cur_set][r];
				load_matrix(next_mat);
			end
			send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
				dir_rows[i].known, dir_rows[i].res);
		end

		// Random phases over the fixed sets and random matrices.
		for (int ph = 0; ph < RandPhases; ph++) begin
			in_valid <= 1'b0;
			for (int r = 0; r < 4; r++)
				next_mat[r] = (ph < NumSets) ? MatSets[(ph + 2) % NumSets][r] : rand_row();
			load_matrix(next_mat);
			for (int n = 0; n < RandWords; n++)
				send_point(rand_coord(), rand_coord(), rand_coord(), 0, none);
		end
		in_valid <= 1'b0;
		wait_idle();

		$display("%0d words checked across %0d matrix settings", words_out,
			RandPhases + NumSets);
		$display("%0d with w zero, %0d saturated", wz_seen, sat_seen);
		if (mismatches == 0 && pending_points.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### sim.f
design/vtpd_pkg.sv
design/vtpd_xform.sv
design/vtpd_div_cell.sv
design/vertex_transform_perspective_divide_unit.sv
tb/sv/tb.sv
